// ===== hdl/train_motor_and_light_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// train motor and light controller: assertion macros
// shared macros for the concurrent checks of the controller
// ----------------------------------------------------------------------------
`ifndef TRAIN_MOTOR_AND_LIGHT_CONTROLLER_UNIT_DEFINES_SVH
`define TRAIN_MOTOR_AND_LIGHT_CONTROLLER_UNIT_DEFINES_SVH

// check sampled on clock, switched off while reset is high
`define TMLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check sampled on clock at every edge, reset included
`define TMLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/tmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmlc_pkg
// codes, constants and types of the motor and light controller
// ----------------------------------------------------------------------------
package tmlc_pkg;

   // command codes
   localparam logic [2:0] ACT_SET_SPEED = 3'd0;
   localparam logic [2:0] ACT_ESTOP     = 3'd1;
   localparam logic [2:0] ACT_SET_FN    = 3'd2;
   localparam logic [2:0] ACT_TICK      = 3'd3;
   localparam logic [2:0] ACT_READ_FN   = 3'd4;

   // lamp phase codes
   localparam logic [2:0] PH_STEADY  = 3'd0;
   localparam logic [2:0] PH_SLOW_A  = 3'd1;
   localparam logic [2:0] PH_MED_A   = 3'd2;
   localparam logic [2:0] PH_FAST_A  = 3'd3;
   localparam logic [2:0] PH_SLOW_B  = 3'd4;
   localparam logic [2:0] PH_MED_B   = 3'd5;
   localparam logic [2:0] PH_FAST_B  = 3'd6;
   localparam logic [2:0] PH_NEVER   = 3'd7;

   // register indexes
   localparam logic CSR_PHASE  = 1'b0;
   localparam logic CSR_BRIGHT = 1'b1;

   // channels and duty values
   localparam logic [2:0] CH_SIDE_A    = 3'd0;
   localparam logic [2:0] CH_SIDE_B    = 3'd1;
   localparam logic [2:0] CH_LAMP_BASE = 3'd2;
   localparam logic [6:0] DUTY_FULL    = 7'd100;
   localparam logic [6:0] DUTY_OFF     = 7'd0;

   // speed cap in 8.8 mph (128.0) and its shift
   localparam logic [15:0] SPEED_CAP   = 16'd32768;
   localparam int          SPEED_SHIFT = 15;

   // result list depth
   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = 3;

   // one duty write or read answer
   typedef struct packed {
      logic [2:0] channel;
      logic [6:0] duty;
      logic       hold_before;
      logic       is_read;
      logic       read_value;
   } rsp_entry_type;

   // a result slot that may or may not be produced
   typedef struct packed {
      logic          en;
      rsp_entry_type e;
   } cand_type;

endpackage

// ===== hdl/train_motor_and_light_controller_unit.sv =====
// ----------------------------------------------------------------------------
// train_motor_and_light_controller_unit
// h-bridge motor and lamp duty writer of a model-train decoder
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  action, forward, speed, fn, blink
// rsp       out        rsp_valid/rsp_stall  channel, duty, hold, read, last
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// a request is taken into an input register, then its whole result list
// (0 to 6 entries) is built and loaded into the result list register
// the list drains one entry per cycle while rsp_stall is low
// the next list loads in the cycle the last entry is taken; rsp_stall holds it
// reset is synchronous and clears direction, master, lamp and register state
// ----------------------------------------------------------------------------
`include "train_motor_and_light_controller_unit_defines.svh"

module train_motor_and_light_controller_unit #(
   parameter int LAMP_COUNT = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_action,
   input  logic                    req_forward,
   input  logic [15:0]             req_speed_mph,
   input  logic [3:0]              req_fn_number,
   input  logic                    req_fn_on,
   input  logic                    req_blink_fast,
   input  logic                    req_blink_medium,
   input  logic                    req_blink_slow,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_channel,
   output logic [6:0]              rsp_duty,
   output logic                    rsp_hold_before,
   output logic                    rsp_is_read,
   output logic                    rsp_read_value,
   output logic                    rsp_last,
   // register write port
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [7*LAMP_COUNT-1:0] csr_wdata
);

   localparam int PHASE_W    = 3 * LAMP_COUNT;
   localparam int BRIGHT_W   = 7 * LAMP_COUNT;
   localparam int LAMP_IDX_W = $clog2(LAMP_COUNT);
   localparam int CAND_N     = (LAMP_COUNT > 6) ? LAMP_COUNT : 6;

   // configuration and decoder state
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [BRIGHT_W-1:0]   bright_ff, bright_in;
   logic                  motor_fwd_ff, motor_fwd_in;
   logic                  speed_fwd_ff, speed_fwd_in;
   logic                  master_ff, master_in;
   logic [LAMP_COUNT-1:0] lamp_on_ff, lamp_on_in;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [2:0]            s1_action_ff, s1_action_in;
   logic                  s1_forward_ff, s1_forward_in;
   logic [15:0]           s1_speed_ff, s1_speed_in;
   logic [3:0]            s1_fn_ff, s1_fn_in;
   logic                  s1_fn_on_ff, s1_fn_on_in;
   logic                  s1_fast_ff, s1_fast_in;
   logic                  s1_medium_ff, s1_medium_in;
   logic                  s1_slow_ff, s1_slow_in;

   // result list register
   tmlc_pkg::rsp_entry_type list_ff [tmlc_pkg::MAX_RESULTS];
   tmlc_pkg::rsp_entry_type list_in [tmlc_pkg::MAX_RESULTS];
   logic [tmlc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [tmlc_pkg::CNT_W-1:0] rd_ff, rd_in;

   // list build
   tmlc_pkg::cand_type         cand [CAND_N];
   tmlc_pkg::rsp_entry_type    calc_list [tmlc_pkg::MAX_RESULTS];
   logic [tmlc_pkg::CNT_W-1:0] calc_cnt;

   logic                  req_take;
   logic                  rsp_take;
   logic                  list_done;
   logic                  list_free;
   logic                  move;
   logic [15:0]           mph_cap;
   logic [22:0]           fill_prod;
   logic [6:0]            fill_duty;
   logic                  fn_is_lamp;
   logic [LAMP_IDX_W-1:0] fn_idx;

   // saturate a brightness field to 100 percent
   function automatic logic [6:0] sat_bright(input logic [6:0] b);
      return (b > tmlc_pkg::DUTY_FULL) ? tmlc_pkg::DUTY_FULL : b;
   endfunction

   // duty write caused by switching one lamp on or off
   function automatic tmlc_pkg::cand_type lamp_set(input logic [LAMP_IDX_W-1:0] idx,
                                                   input logic on);
      tmlc_pkg::cand_type c;
      logic [2:0]         ph;
      logic [6:0]         br;
      ph          = phase_ff[3*idx +: 3];
      br          = sat_bright(bright_ff[7*idx +: 7]);
      c           = '0;
      c.en        = !on || (ph == tmlc_pkg::PH_STEADY);
      c.e.channel = 3'(idx) + tmlc_pkg::CH_LAMP_BASE;
      c.e.duty    = on ? br : tmlc_pkg::DUTY_OFF;
      return c;
   endfunction

   // handshakes
   assign rsp_valid = (cnt_ff != '0);
   assign list_done = (rd_ff == cnt_ff - 3'd1);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign list_free = !rsp_valid || (rsp_take && list_done);
   assign move      = s1_valid_ff && list_free;
   assign req_stall = s1_valid_ff && !list_free;
   assign req_take  = req_valid && !req_stall;

   // result outputs
   assign rsp_channel     = list_ff[rd_ff].channel;
   assign rsp_duty        = list_ff[rd_ff].duty;
   assign rsp_hold_before = list_ff[rd_ff].hold_before;
   assign rsp_is_read     = list_ff[rd_ff].is_read;
   assign rsp_read_value  = list_ff[rd_ff].read_value;
   assign rsp_last        = list_done;

   // trailing side duty: min(mph,128.0)*100/128.0
   assign mph_cap   = (s1_speed_ff > tmlc_pkg::SPEED_CAP) ? tmlc_pkg::SPEED_CAP : s1_speed_ff;
   assign fill_prod = 23'(mph_cap) * 23'd100;
   assign fill_duty = fill_prod[tmlc_pkg::SPEED_SHIFT +: 7];

   // function number decode
   assign fn_is_lamp = (s1_fn_ff != 4'd0) && (s1_fn_ff <= 4'(LAMP_COUNT));
   assign fn_idx     = LAMP_IDX_W'(s1_fn_ff - 4'd1);

   // input register next
   always_comb begin
      s1_valid_in  = req_take ? 1'b1 : (move ? 1'b0 : s1_valid_ff);
      s1_action_in = req_take ? req_action       : s1_action_ff;
      s1_forward_in = req_take ? req_forward     : s1_forward_ff;
      s1_speed_in  = req_take ? req_speed_mph    : s1_speed_ff;
      s1_fn_in     = req_take ? req_fn_number    : s1_fn_ff;
      s1_fn_on_in  = req_take ? req_fn_on        : s1_fn_on_ff;
      s1_fast_in   = req_take ? req_blink_fast   : s1_fast_ff;
      s1_medium_in = req_take ? req_blink_medium : s1_medium_ff;
      s1_slow_in   = req_take ? req_blink_slow   : s1_slow_ff;
   end

   // command decode: result slots in order and state update
   always_comb begin
      logic [2:0] ph;
      logic       lit;
      logic       hold;
      for (int k = 0; k < CAND_N; k++) begin
         cand[k] = '0;
      end
      motor_fwd_in = motor_fwd_ff;
      speed_fwd_in = speed_fwd_ff;
      master_in    = master_ff;
      lamp_on_in   = lamp_on_ff;
      ph           = tmlc_pkg::PH_STEADY;
      lit          = 1'b0;
      hold         = 1'b0;
      if (move) begin
         unique case (s1_action_ff)
            tmlc_pkg::ACT_SET_SPEED: begin
               speed_fwd_in = s1_forward_ff;
               motor_fwd_in = s1_forward_ff;
               // direction change: brake both sides first
               if (motor_fwd_ff != s1_forward_ff) begin
                  hold              = 1'b1;
                  cand[0].en        = 1'b1;
                  cand[0].e.channel = tmlc_pkg::CH_SIDE_A;
                  cand[0].e.duty    = tmlc_pkg::DUTY_FULL;
                  cand[1].en        = 1'b1;
                  cand[1].e.channel = tmlc_pkg::CH_SIDE_B;
                  cand[1].e.duty    = tmlc_pkg::DUTY_FULL;
               end
               cand[2].en            = 1'b1;
               cand[2].e.channel     = s1_forward_ff ? tmlc_pkg::CH_SIDE_B
                                                     : tmlc_pkg::CH_SIDE_A;
               cand[2].e.duty        = tmlc_pkg::DUTY_FULL;
               cand[2].e.hold_before = hold;
               cand[3].en            = 1'b1;
               cand[3].e.channel     = s1_forward_ff ? tmlc_pkg::CH_SIDE_A
                                                     : tmlc_pkg::CH_SIDE_B;
               cand[3].e.duty        = fill_duty;
               // headlights follow the direction while the master is on
               if (master_ff) begin
                  if (s1_forward_ff) begin
                     cand[4]       = lamp_set(LAMP_IDX_W'(1), 1'b0);
                     cand[5]       = lamp_set(LAMP_IDX_W'(0), 1'b1);
                     lamp_on_in[1] = 1'b0;
                     lamp_on_in[0] = 1'b1;
                  end else begin
                     cand[4]       = lamp_set(LAMP_IDX_W'(0), 1'b0);
                     cand[5]       = lamp_set(LAMP_IDX_W'(1), 1'b1);
                     lamp_on_in[0] = 1'b0;
                     lamp_on_in[1] = 1'b1;
                  end
               end
            end
            tmlc_pkg::ACT_ESTOP: begin
               for (int k = 0; k < 4; k++) begin
                  cand[k].en        = 1'b1;
                  cand[k].e.channel = (k % 2 == 0) ? tmlc_pkg::CH_SIDE_A
                                                   : tmlc_pkg::CH_SIDE_B;
                  cand[k].e.duty    = (k < 2) ? tmlc_pkg::DUTY_FULL : tmlc_pkg::DUTY_OFF;
               end
               cand[2].e.hold_before = 1'b1;
            end
            tmlc_pkg::ACT_SET_FN: begin
               if (s1_fn_ff == 4'd0) begin
                  // headlight master
                  master_in     = s1_fn_on_ff;
                  lamp_on_in[0] = s1_fn_on_ff && speed_fwd_ff;
                  lamp_on_in[1] = s1_fn_on_ff && !speed_fwd_ff;
                  cand[0] = lamp_set(LAMP_IDX_W'(0), s1_fn_on_ff && speed_fwd_ff);
                  cand[1] = lamp_set(LAMP_IDX_W'(1), s1_fn_on_ff && !speed_fwd_ff);
               end else if (fn_is_lamp) begin
                  lamp_on_in[fn_idx] = s1_fn_on_ff;
                  cand[0]            = lamp_set(fn_idx, s1_fn_on_ff);
               end
            end
            tmlc_pkg::ACT_TICK: begin
               // every lit blinking lamp gets its level for this tick
               for (int i = 0; i < LAMP_COUNT; i++) begin
                  ph = phase_ff[3*i +: 3];
                  case (ph)
                     tmlc_pkg::PH_SLOW_A: lit = s1_slow_ff;
                     tmlc_pkg::PH_MED_A:  lit = s1_medium_ff;
                     tmlc_pkg::PH_FAST_A: lit = s1_fast_ff;
                     tmlc_pkg::PH_SLOW_B: lit = !s1_slow_ff;
                     tmlc_pkg::PH_MED_B:  lit = !s1_medium_ff;
                     tmlc_pkg::PH_FAST_B: lit = !s1_fast_ff;
                     default:             lit = 1'b0;
                  endcase
                  cand[i].en        = lamp_on_ff[i] && (ph != tmlc_pkg::PH_STEADY)
                                      && (ph != tmlc_pkg::PH_NEVER);
                  cand[i].e.channel = 3'(i) + tmlc_pkg::CH_LAMP_BASE;
                  cand[i].e.duty    = lit ? sat_bright(bright_ff[7*i +: 7])
                                          : tmlc_pkg::DUTY_OFF;
               end
            end
            tmlc_pkg::ACT_READ_FN: begin
               cand[0].en        = 1'b1;
               cand[0].e.is_read = 1'b1;
               if (s1_fn_ff == 4'd0) begin
                  cand[0].e.read_value = master_ff;
               end else if (fn_is_lamp) begin
                  cand[0].e.read_value = lamp_on_ff[fn_idx];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // pack the produced slots into the result list
   always_comb begin
      logic [tmlc_pkg::CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < tmlc_pkg::MAX_RESULTS; k++) begin
         calc_list[k] = '0;
      end
      for (int k = 0; k < CAND_N; k++) begin
         if (cand[k].en && (n < 3'(tmlc_pkg::MAX_RESULTS))) begin
            calc_list[n] = cand[k].e;
            n            = n + 3'd1;
         end
      end
      calc_cnt = n;
   end

   // result list next
   always_comb begin
      list_in = list_ff;
      cnt_in  = cnt_ff;
      rd_in   = rd_ff;
      if (move) begin
         list_in = calc_list;
         cnt_in  = calc_cnt;
         rd_in   = '0;
      end else if (rsp_take) begin
         if (list_done) begin
            cnt_in = '0;
            rd_in  = '0;
         end else begin
            rd_in = rd_ff + 3'd1;
         end
      end
   end

   // register writes
   always_comb begin
      phase_in  = phase_ff;
      bright_in = bright_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tmlc_pkg::CSR_PHASE:  phase_in  = csr_wdata[PHASE_W-1:0];
            tmlc_pkg::CSR_BRIGHT: bright_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         bright_ff    <= '0;
         motor_fwd_ff <= 1'b0;
         speed_fwd_ff <= 1'b0;
         master_ff    <= 1'b0;
         lamp_on_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         rd_ff        <= '0;
      end else begin
         phase_ff     <= phase_in;
         bright_ff    <= bright_in;
         motor_fwd_ff <= motor_fwd_in;
         speed_fwd_ff <= speed_fwd_in;
         master_ff    <= master_in;
         lamp_on_ff   <= lamp_on_in;
         s1_valid_ff  <= s1_valid_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_action_ff  <= s1_action_in;
      s1_forward_ff <= s1_forward_in;
      s1_speed_ff   <= s1_speed_in;
      s1_fn_ff      <= s1_fn_in;
      s1_fn_on_ff   <= s1_fn_on_in;
      s1_fast_ff    <= s1_fast_in;
      s1_medium_ff  <= s1_medium_in;
      s1_slow_ff    <= s1_slow_in;
      list_ff       <= list_in;
   end

   // checks
   `TMLC_ASSERT_ALWAYS(a_reset_clears_list, reset |=> (cnt_ff == '0 && !s1_valid_ff), "list not empty after reset")
   `TMLC_ASSERT(a_rd_in_range, rsp_valid |-> (rd_ff < cnt_ff && cnt_ff <= 3'(tmlc_pkg::MAX_RESULTS)), "read index out of list")
   `TMLC_ASSERT(a_stall_holds_index, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rd_ff)), "stalled result moved")
   `TMLC_ASSERT(a_estop_four_writes, (move && s1_action_ff == tmlc_pkg::ACT_ESTOP) |=> (cnt_ff == 3'd4 && rd_ff == '0), "emergency stop list wrong")
   `TMLC_ASSERT(a_stall_only_when_held, req_stall |-> (s1_valid_ff && rsp_valid), "request stalled with free list")

endmodule
